>>> rtl/vrpva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrpva_pkg
// Shared types and constants of the video register port.
// ----------------------------------------------------------------------------
package vrpva_pkg;

  localparam int NAME_RAM_BYTES   = 2048;
  localparam int PALETTE_BYTES    = 32;
  localparam int SPRITE_RAM_BYTES = 256;

  localparam int NT_AW  = $clog2(NAME_RAM_BYTES);
  localparam int PAL_AW = $clog2(PALETTE_BYTES);
  localparam int SPR_AW = $clog2(SPRITE_RAM_BYTES);

  localparam logic [7:0] STATUS_RESET = 8'hA0;

  typedef enum logic [1:0] {
    OP_REG_WRITE    = 2'd0,
    OP_REG_READ     = 2'd1,
    OP_VBLANK_START = 2'd2,
    OP_VBLANK_END   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_CTRL      = 3'd0,
    REG_MASK      = 3'd1,
    REG_STATUS    = 3'd2,
    REG_OAM_ADDR  = 3'd3,
    REG_OAM_DATA  = 3'd4,
    REG_SCROLL    = 3'd5,
    REG_ADDR      = 3'd6,
    REG_DATA      = 3'd7
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the item and start the nametable read
    logic execute;   // apply the item and load the result registers
  } dp_cmd_t;

endpackage

>>> rtl/vrpva_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrpva_ctrl
// Sequencer for item capture, execution and result handoff.
// ----------------------------------------------------------------------------
module vrpva_ctrl
  import vrpva_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // The item is applied only once the result register can take it.
        if (out_free) begin
          cmd.execute = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.execute) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/vrpva_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrpva_datapath
// Register file, address latches, nametable, palette and sprite memories.
// ----------------------------------------------------------------------------
module vrpva_datapath
  import vrpva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic        cfg_we,
  input  logic        cfg_mirroring,
  input  logic [1:0]  op,
  input  logic [2:0]  reg_index,
  input  logic [7:0]  write_data,
  input  logic [7:0]  chr_data,
  output logic [7:0]  read_data,
  output logic        nmi_pulse,
  output logic        chr_write_en,
  output logic [12:0] chr_addr,
  output logic [7:0]  chr_write_value,
  output logic [14:0] vram_addr,
  output logic [14:0] temp_addr,
  output logic [2:0]  fine_scroll_x,
  output logic [7:0]  control_value,
  output logic [7:0]  mask_value
);

  // Architectural state.
  logic              mirroring;
  logic [7:0]        control_reg;
  logic [7:0]        mask_reg;
  logic [7:0]        status_reg;
  logic [14:0]       current_addr;
  logic [14:0]       temp_addr_reg;
  logic [2:0]        fine_x_reg;
  logic              write_toggle;
  logic [7:0]        read_buffer;
  logic [SPR_AW-1:0] sprite_ptr;

  logic [7:0] name_ram    [NAME_RAM_BYTES];
  logic [7:0] palette_ram [PALETTE_BYTES];
  logic [7:0] sprite_ram  [SPRITE_RAM_BYTES];

  // Captured item.
  op_t        op_q;
  reg_idx_t   reg_q;
  logic [7:0] wd_q;
  logic [7:0] cd_q;
  logic [7:0] nt_rdata;
  logic [7:0] pal_rdata;

  // Next values.
  logic [7:0]        control_next;
  logic [7:0]        mask_next;
  logic [7:0]        status_next;
  logic [14:0]       current_next;
  logic [14:0]       temp_next;
  logic [2:0]        fine_x_next;
  logic              toggle_next;
  logic [7:0]        buffer_next;
  logic [SPR_AW-1:0] sprite_ptr_next;
  logic [7:0]        rd_next;
  logic              nmi_next;
  logic              cwe_next;
  logic [12:0]       caddr_next;
  logic [7:0]        cval_next;
  logic              nt_we;
  logic              pal_we;
  logic              spr_we;

  // Address decode of the current VRAM address.
  logic [13:0]       acc_addr;
  logic              in_chr;
  logic              in_pal;
  logic [NT_AW-1:0]  nt_idx;
  logic [PAL_AW-1:0] pal_idx;
  logic [14:0]       addr_stepped;
  logic [7:0]        mem_value;

  assign acc_addr = current_addr[13:0];
  assign in_chr   = !acc_addr[13];
  assign in_pal   = (acc_addr[13:8] == 6'h3F);

  // The table select bit comes from bit 10 for vertical and bit 11 for
  // horizontal mirroring.
  always_comb begin
    nt_idx        = '0;
    nt_idx[9:0]   = acc_addr[9:0];
    nt_idx[10]    = mirroring ? acc_addr[10] : acc_addr[11];
  end

  // Sprite palette entries that alias the background entries at offset zero.
  always_comb begin
    pal_idx = acc_addr[PAL_AW-1:0];
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
  end

  assign addr_stepped = current_addr + (control_reg[2] ? 15'd32 : 15'd1);

  always_comb begin
    priority if (in_chr) begin
      mem_value = cd_q;
    end else if (!in_pal) begin
      mem_value = nt_rdata;
    end else begin
      mem_value = pal_rdata;
    end
  end

  always_comb begin
    control_next    = control_reg;
    mask_next       = mask_reg;
    status_next     = status_reg;
    current_next    = current_addr;
    temp_next       = temp_addr_reg;
    fine_x_next     = fine_x_reg;
    toggle_next     = write_toggle;
    buffer_next     = read_buffer;
    sprite_ptr_next = sprite_ptr;
    rd_next         = 8'h00;
    nmi_next        = 1'b0;
    cwe_next        = 1'b0;
    caddr_next      = 13'h0000;
    cval_next       = 8'h00;
    nt_we           = 1'b0;
    pal_we          = 1'b0;
    spr_we          = 1'b0;
    unique case (op_q)
      OP_REG_WRITE: begin
        unique case (reg_q)
          REG_CTRL: begin
            control_next     = wd_q;
            temp_next[11:10] = wd_q[1:0];
          end
          REG_MASK: begin
            mask_next = wd_q;
          end
          REG_OAM_ADDR: begin
            sprite_ptr_next = wd_q[SPR_AW-1:0];
          end
          REG_OAM_DATA: begin
            spr_we          = 1'b1;
            sprite_ptr_next = sprite_ptr + 1'b1;
          end
          REG_SCROLL: begin
            if (!write_toggle) begin
              fine_x_next    = wd_q[2:0];
              temp_next[4:0] = wd_q[7:3];
              toggle_next    = 1'b1;
            end else begin
              temp_next[14:12] = wd_q[2:0];
              temp_next[9:5]   = wd_q[7:3];
              toggle_next      = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!write_toggle) begin
              temp_next[13:8] = wd_q[5:0];
              temp_next[14]   = 1'b0;
              toggle_next     = 1'b1;
            end else begin
              temp_next[7:0]  = wd_q;
              current_next    = {temp_addr_reg[14:8], wd_q};
              toggle_next     = 1'b0;
            end
          end
          REG_DATA: begin
            caddr_next   = acc_addr[12:0];
            current_next = addr_stepped;
            priority if (in_chr) begin
              cwe_next  = 1'b1;
              cval_next = wd_q;
            end else if (!in_pal) begin
              nt_we = 1'b1;
            end else begin
              pal_we = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      OP_REG_READ: begin
        if (reg_q == REG_STATUS) begin
          rd_next        = status_reg;
          status_next[7] = 1'b0;
          toggle_next    = 1'b0;
        end else if (reg_q == REG_DATA) begin
          caddr_next   = acc_addr[12:0];
          current_next = addr_stepped;
          rd_next      = in_pal ? mem_value : read_buffer;
          buffer_next  = mem_value;
        end
      end
      OP_VBLANK_START: begin
        status_next[7] = 1'b1;
        nmi_next       = control_reg[7];
      end
      OP_VBLANK_END: begin
        status_next[7] = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Nametable: the read is issued at capture, the write lands at execute.
  // The current address does not move in between, so both use one index.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nt_rdata <= name_ram[nt_idx];
    end
    if (cmd.execute && nt_we) begin
      name_ram[nt_idx] <= wd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && spr_we) begin
      sprite_ram[sprite_ptr] <= wd_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q      <= op_t'(op);
      reg_q     <= reg_idx_t'(reg_index);
      wd_q      <= write_data;
      cd_q      <= chr_data;
      pal_rdata <= palette_ram[pal_idx];
    end
    if (cmd.execute) begin
      read_data       <= rd_next;
      nmi_pulse       <= nmi_next;
      chr_write_en    <= cwe_next;
      chr_addr        <= caddr_next;
      chr_write_value <= cval_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mirroring     <= 1'b0;
      control_reg   <= 8'h00;
      mask_reg      <= 8'h00;
      status_reg    <= STATUS_RESET;
      current_addr  <= 15'h0000;
      temp_addr_reg <= 15'h0000;
      fine_x_reg    <= 3'd0;
      write_toggle  <= 1'b0;
      read_buffer   <= 8'h00;
      sprite_ptr    <= '0;
      for (int i = 0; i < PALETTE_BYTES; i++) begin
        palette_ram[i] <= 8'h00;
      end
    end else begin
      if (cfg_we) begin
        mirroring <= cfg_mirroring;
      end
      if (cmd.execute) begin
        control_reg   <= control_next;
        mask_reg      <= mask_next;
        status_reg    <= status_next;
        current_addr  <= current_next;
        temp_addr_reg <= temp_next;
        fine_x_reg    <= fine_x_next;
        write_toggle  <= toggle_next;
        read_buffer   <= buffer_next;
        sprite_ptr    <= sprite_ptr_next;
        if (pal_we) begin
          palette_ram[pal_idx] <= wd_q;
        end
      end
    end
  end

  assign vram_addr     = current_addr;
  assign temp_addr     = temp_addr_reg;
  assign fine_scroll_x = fine_x_reg;
  assign control_value = control_reg;
  assign mask_value    = mask_reg;

endmodule

>>> rtl/video_register_port_vram_access_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_register_port_vram_access_core
// CPU register port of a tile video processor with nametable and palette.
// ----------------------------------------------------------------------------
// Each item (a CPU register write, a CPU register read, or a vblank start or
// end event) is accepted in S_IDLE, while the synchronous nametable and
// palette RAMs are read at the current VRAM address, and is applied in S_EXEC,
// when its result is loaded into the output register. in_stall is high in
// S_EXEC, so no new item is accepted until the last one is applied; a stalled
// result holds the item in execution. The vram_addr, temp_addr, fine_scroll_x,
// control_value and mask_value outputs show the state after the item of the
// result being presented. The mirroring register may be written at any time
// the block is idle; cfg_ready is always high.
module video_register_port_vram_access_core
  import vrpva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        mirror_vertical,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  reg_index,
  input  logic [7:0]  write_data,
  input  logic [7:0]  chr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        nmi_pulse,
  output logic        chr_write_en,
  output logic [12:0] chr_addr,
  output logic [7:0]  chr_write_value,
  output logic [14:0] vram_addr,
  output logic [14:0] temp_addr,
  output logic [2:0]  fine_scroll_x,
  output logic [7:0]  control_value,
  output logic [7:0]  mask_value
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  vrpva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  vrpva_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_we          (cfg_valid),
    .cfg_mirroring   (mirror_vertical),
    .op              (op),
    .reg_index       (reg_index),
    .write_data      (write_data),
    .chr_data        (chr_data),
    .read_data       (read_data),
    .nmi_pulse       (nmi_pulse),
    .chr_write_en    (chr_write_en),
    .chr_addr        (chr_addr),
    .chr_write_value (chr_write_value),
    .vram_addr       (vram_addr),
    .temp_addr       (temp_addr),
    .fine_scroll_x   (fine_scroll_x),
    .control_value   (control_value),
    .mask_value      (mask_value)
  );

endmodule
